// File: rtl/core/srbk_pkg.sv
// Shared types and constants for the keyed-removal stack.
// No dependencies; compiled first.
package srbk_pkg;

  localparam int unsigned KEY_W         = 31;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned MOVES_W       = 5;
  localparam int unsigned MOVES_MAX     = 31;
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_REMOVE,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_APPLY
  } back_state_t;

endpackage

// File: rtl/core/srbk_in_if.sv
// Command channel: valid/ready handshake carrying cmd and plate.
// Depends on srbk_pkg.
interface srbk_in_if;
  logic                        valid;
  logic                        ready;
  logic [srbk_pkg::CMD_W-1:0]  cmd;
  logic [srbk_pkg::KEY_W-1:0]  plate;

  modport source (output valid, output cmd, output plate, input ready);
  modport sink   (input valid, input cmd, input plate, output ready);
endinterface

// File: rtl/core/srbk_out_if.sv
// Result channel: valid/ready handshake carrying status and moves.
// Depends on srbk_pkg.
interface srbk_out_if;
  logic                           valid;
  logic                           ready;
  logic [srbk_pkg::STATUS_W-1:0]  status;
  logic [srbk_pkg::MOVES_W-1:0]   moves;

  modport source (output valid, output status, output moves, input ready);
  modport sink   (input valid, input status, input moves, output ready);
endinterface

// File: rtl/core/srbk_front.sv
// Front end: accepts command transactions, decodes them into jobs and
// buffers them in a two-entry queue. Depends on srbk_pkg, srbk_in_if.
module srbk_front (
  input  logic            clk,
  input  logic            rst,
  srbk_in_if.sink         req,
  output logic            job_valid,
  output srbk_pkg::job_t  job,
  input  logic            job_pop
);
  import srbk_pkg::*;

  job_t              q_job [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push_q;
  logic              pop_q;
  job_t              decoded;

  always_comb begin
    decoded.key = req.plate;
    case (req.cmd)
      CMD_PUSH:   decoded.op = OP_PUSH;
      CMD_REMOVE: decoded.op = OP_REMOVE;
      default:    decoded.op = OP_BAD;
    endcase
  end

  assign req.ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push_q    = req.valid && req.ready;
  assign job_valid = (count != '0);
  assign pop_q     = job_pop && job_valid;
  assign job       = q_job[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_job[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_q) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_q) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_q, pop_q})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/srbk_back.sv
// Back end: register-file stack with parallel key compare and gap-closing
// shift, plus the result register. Depends on srbk_pkg, srbk_out_if.
module srbk_back #(
  parameter int unsigned DEPTH = srbk_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  srbk_pkg::job_t  job,
  output logic            job_pop,
  srbk_out_if.source      rsp
);
  import srbk_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] slot [DEPTH];
  logic [CNT_W-1:0] fill;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] shift_en;

  back_state_t      state;
  back_state_t      state_next;

  logic             out_free;
  logic             load;
  logic             push_do;
  logic             scan_do;
  logic             apply_do;
  status_t          res_status;
  logic [MOVES_W-1:0] res_moves;

  logic             hit;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] taken;
  logic [MOVES_W-1:0] taken_sat;

  assign out_free = !rsp.valid || rsp.ready;

  // Highest matching entry is the one nearest the top.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign taken     = hit ? (fill - pos) : fill;
  assign taken_sat = (32'(taken) > MOVES_MAX) ? MOVES_W'(MOVES_MAX) : MOVES_W'(taken);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_en[i] = apply_do && hit && (CNT_W'(i) >= pos)
                    && ((CNT_W+1)'(i + 1) < {1'b0, fill});
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (job_valid && job.op == OP_REMOVE && fill != '0) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN:  state_next = BK_APPLY;
      BK_APPLY: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default:  state_next = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    load       = 1'b0;
    push_do    = 1'b0;
    scan_do    = 1'b0;
    apply_do   = 1'b0;
    job_pop    = 1'b0;
    res_status = ST_DONE;
    res_moves  = '0;
    case (state)
      BK_IDLE: begin
        if (job_valid && out_free) begin
          case (job.op)
            OP_PUSH: begin
              load    = 1'b1;
              job_pop = 1'b1;
              if (fill == CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                push_do   = 1'b1;
                res_moves = MOVES_W'(1);
              end
            end
            OP_REMOVE: begin
              if (fill == '0) begin
                load    = 1'b1;
                job_pop = 1'b1;
              end
            end
            default: begin
              load       = 1'b1;
              job_pop    = 1'b1;
              res_status = ST_BAD;
            end
          endcase
        end
      end
      BK_SCAN: scan_do = 1'b1;
      BK_APPLY: begin
        if (out_free) begin
          apply_do  = 1'b1;
          load      = 1'b1;
          job_pop   = 1'b1;
          res_moves = taken_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (push_do) begin
        fill <= fill + 1'b1;
      end else if (apply_do && hit) begin
        fill <= fill - 1'b1;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (scan_do) begin
        match[g] <= (slot[g] == job.key) && (CNT_W'(g) < fill);
      end
    end

    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (push_do && fill == CNT_W'(g)) begin
          slot[g] <= job.key;
        end else if (shift_en[g]) begin
          slot[g] <= slot[g+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (push_do && fill == CNT_W'(g)) begin
          slot[g] <= job.key;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status <= res_status;
      rsp.moves  <= res_moves;
    end
  end

endmodule

// File: rtl/core/stack_remove_by_key.sv
// Bounded LIFO key stack with push and remove-by-key.
// Push, invalid command or remove on an empty stack: result registered straight from idle;
// other removes take the registered compare pass, then the shift pass in srbk_back.
// One push per cycle if rsp is free; removes stall later jobs. A two-entry queue sits ahead.
// Reset (rst, synchronous) empties the stack and queue; slot contents stay undefined.
// Depends on srbk_pkg, srbk_in_if, srbk_out_if, srbk_front, srbk_back.
module stack_remove_by_key #(
  parameter int unsigned DEPTH = srbk_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  srbk_in_if.sink     req,
  srbk_out_if.source  rsp
);
  import srbk_pkg::*;

  logic job_valid;
  job_t job;
  logic job_pop;

  srbk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  srbk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rsp       (rsp)
  );

endmodule
